[hw/rtl/sat_pkg.sv]
// Shared types, constants and helpers for the shell argument tokenizer.
package sat_pkg;

	localparam int unsigned LIMIT_W = 10;
	localparam logic [LIMIT_W-1:0] TOKEN_LIMIT_RESET = 10'd997;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_TEND = 2'd1;
	localparam logic [1:0] KIND_LEND = 2'd2;
	localparam logic [1:0] KIND_OVF  = 2'd3;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	typedef enum logic [2:0] {
		ST_SKIP    = 3'd0,
		ST_TOK     = 3'd1,
		ST_Q1      = 3'd2,
		ST_Q2      = 3'd3,
		ST_Q1_ESC  = 3'd4,
		ST_Q2_ESC  = 3'd5,
		ST_TOK_ESC = 3'd6
	} sat_state_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       line_end;
	} sat_in_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic       last;
	} sat_out_t;

	typedef struct packed {
		logic     push0;
		logic     push1;
		sat_out_t res0;
		sat_out_t res1;
	} sat_push_t;

	function automatic logic is_space(input logic [7:0] c);
		logic r;
		r = c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
		return r;
	endfunction

endpackage

[hw/rtl/sat_step.sv]
// Parser state registers and the per-byte transition that forms the results.
module sat_step
	import sat_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  sat_in_t             item,
	input  logic                cfg_we,
	input  logic [LIMIT_W-1:0]  cfg_data,
	output sat_push_t           push
);

	sat_state_t         state_q, state_d;
	logic               open_q, open_d;
	logic [LIMIT_W-1:0] count_q, count_d;
	logic               drop_q, drop_d;
	logic [LIMIT_W-1:0] limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SKIP;
			open_q  <= 1'b0;
			count_q <= '0;
			drop_q  <= 1'b0;
			limit_q <= TOKEN_LIMIT_RESET;
		end else begin
			if (fire) begin
				state_q <= state_d;
				open_q  <= open_d;
				count_q <= count_d;
				drop_q  <= drop_d;
			end
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
		end
	end

	always_comb begin
		logic [7:0] c;
		logic       sp;
		logic       keep;
		logic       skipping;
		sat_state_t st;

		c        = item.in_byte;
		sp       = is_space(c);
		keep     = 1'b0;
		skipping = 1'b0;
		st       = state_q;
		state_d  = state_q;
		open_d   = open_q;
		count_d  = count_q;
		drop_d   = drop_q;
		push     = '0;

		if (item.line_end) begin
			if (open_q && !drop_q) begin
				push.push0 = 1'b1;
				push.res0  = '{kind: KIND_TEND, out_byte: 8'd0, last: 1'b0};
				push.push1 = 1'b1;
				push.res1  = '{kind: KIND_LEND, out_byte: 8'd0, last: 1'b1};
			end else begin
				push.push0 = 1'b1;
				push.res0  = '{kind: KIND_LEND, out_byte: 8'd0, last: 1'b1};
			end
			state_d = ST_SKIP;
			open_d  = 1'b0;
			count_d = '0;
			drop_d  = 1'b0;
		end else if (!drop_q) begin
			case (state_q)
				ST_TOK, ST_Q1, ST_Q2, ST_Q1_ESC, ST_Q2_ESC, ST_TOK_ESC: begin
					st = state_q;
				end
				default: begin
					st       = ST_TOK;
					skipping = sp;
				end
			endcase
			if (skipping) begin
				st = ST_SKIP;
			end else begin
				case (st)
					ST_TOK: begin
						if (c == CH_SQUOTE) begin
							st = ST_Q1;
						end else if (c == CH_DQUOTE) begin
							st = ST_Q2;
						end else if (c == CH_BSLASH) begin
							st = ST_TOK_ESC;
						end else if (sp) begin
							st = ST_SKIP;
							if (open_q) begin
								open_d     = 1'b0;
								push.push0 = 1'b1;
								push.res0  = '{kind: KIND_TEND, out_byte: 8'd0, last: 1'b1};
								if (count_q >= limit_q) begin
									push.res0.last = 1'b0;
									push.push1     = 1'b1;
									push.res1      = '{kind: KIND_OVF, out_byte: 8'd0,
										last: 1'b1};
									drop_d         = 1'b1;
								end else begin
									count_d = count_q + 10'd1;
								end
							end
						end else begin
							keep = 1'b1;
						end
					end
					ST_Q1: begin
						if (c == CH_SQUOTE) begin
							st = ST_TOK;
						end else if (c == CH_BSLASH) begin
							st = ST_Q1_ESC;
						end else begin
							keep = 1'b1;
						end
					end
					ST_Q2: begin
						if (c == CH_DQUOTE) begin
							st = ST_TOK;
						end else if (c == CH_BSLASH) begin
							st = ST_Q2_ESC;
						end else begin
							keep = 1'b1;
						end
					end
					ST_TOK_ESC: begin
						st   = ST_TOK;
						keep = 1'b1;
					end
					ST_Q1_ESC: begin
						st   = ST_Q1;
						keep = 1'b1;
					end
					default: begin
						st   = ST_Q2;
						keep = 1'b1;
					end
				endcase
			end
			if (keep) begin
				push.push0 = 1'b1;
				push.res0  = '{kind: KIND_BYTE, out_byte: c, last: 1'b1};
				open_d     = 1'b1;
			end
			state_d = st;
		end
	end

endmodule

[hw/rtl/sat_fifo.sv]
// Result queue that takes up to two results per cycle and hands out one.
module sat_fifo
	import sat_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  sat_push_t push,
	input  logic      push_en,
	output logic      room,
	output logic      out_valid,
	input  logic      out_ready,
	output sat_out_t  out_data
);

	sat_out_t         mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             w0;
	logic             w1;
	logic             pop;

	assign w0        = push_en && push.push0;
	assign w1        = push_en && push.push1;
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign out_data  = mem_q[rd_ptr_q];
	assign room      = (cnt_q <= CNT_W'(FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (w0) begin
			mem_q[wr_ptr_q] <= push.res0;
		end
		if (w1) begin
			mem_q[wr_ptr_q + PTR_W'(1)] <= push.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(w0) + PTR_W'(w1);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(w0) + CNT_W'(w1) - CNT_W'(pop);
		end
	end

endmodule

[hw/rtl/shell_argument_tokenizer.sv]
// Top level of the shell argument tokenizer: input register, parser and result queue.
// Each input transfer is held in the input register, then its results are written
// into the result queue. Throughput: one input byte per cycle; a byte with two
// results needs two output transfers, and the four-entry result queue takes a new
// byte only while two entries are free. Reset clears the parser state, the queue
// and the input valid flag; the token limit returns to 997.
module shell_argument_tokenizer
	import sat_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  sat_in_t            in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output sat_out_t           out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [LIMIT_W-1:0] cfg_data
);

	sat_in_t   item_s1;
	logic      valid_s1;
	logic      room;
	logic      fire;
	sat_push_t push;

	assign fire      = valid_s1 && room;
	assign in_ready  = !valid_s1 || fire;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	sat_step u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.item     (item_s1),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.push     (push)
	);

	sat_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_en   (fire),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

[hw/rtl/sat_checker.sv]
// Port-level checks for the shell argument tokenizer and their binding.
module sat_checker
	import sat_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     out_valid,
	input logic     out_ready,
	input sat_out_t out_data
);

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.kind == KIND_BYTE || out_data.out_byte == 8'd0))
		else $error("Marker result carries a nonzero byte.");

	a_lend_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.kind == KIND_LEND) |-> out_data.last)
		else $error("Line end is not the final result of its byte.");

	a_ovf_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.kind == KIND_OVF) |-> out_data.last)
		else $error("Overflow is not the final result of its byte.");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("Stalled result changed before its transfer.");

endmodule

bind shell_argument_tokenizer sat_checker u_sat_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

[tb/shell_argument_tokenizer_tb.sv]
// Self-checking testbench for the shell argument tokenizer: directed table, then random lines.
module shell_argument_tokenizer_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sat_pkg::*;

	localparam int DRAIN_CYCLES = 8;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 200;
	localparam int MAX_REPORTS = 40;

	typedef struct packed {
		bit                 is_cfg;
		logic [LIMIT_W-1:0] limit;
		sat_in_t            item;
		logic [1:0]         typed;
		sat_out_t           r0;
		sat_out_t           r1;
	} dir_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	sat_in_t            in_data = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	sat_out_t           out_data;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [LIMIT_W-1:0] cfg_data = '0;

	sat_state_t         parse_st = ST_SKIP;
	bit                 tok_open = 1'b0;
	bit                 dropping = 1'b0;
	logic [LIMIT_W-1:0] tok_count = '0;
	logic [LIMIT_W-1:0] tok_limit = TOKEN_LIMIT_RESET;

	sat_out_t due_token_stream[$];
	dir_row_t dir_rows[$];

	int in_idle_pct = 31;
	int out_idle_pct = 47;
	int items_sent = 0;
	int results_checked = 0;
	int overflow_marks = 0;
	int limit_writes = 0;
	int mismatches = 0;

	shell_argument_tokenizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= out_idle_pct);
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
	endtask

	always @(posedge clk) begin : check_results
		sat_out_t want;
		if (arst_n && out_valid && out_ready) begin
			results_checked++;
			if (out_data.kind === KIND_OVF)
				overflow_marks++;
			if (due_token_stream.size() == 0) begin
				report_mismatch("result with none due, kind", out_data.kind, -1);
			end else begin
				want = due_token_stream.pop_front();
				if (out_data.kind !== want.kind)
					report_mismatch("kind", out_data.kind, want.kind);
				if (out_data.out_byte !== want.out_byte)
					report_mismatch("out_byte", out_data.out_byte, want.out_byte);
				if (out_data.last !== want.last)
					report_mismatch("last", out_data.last, want.last);
			end
		end
	end

	function automatic sat_out_t make_result(input logic [1:0] kind, input logic [7:0] b);
		sat_out_t r;
		r.kind = kind;
		r.out_byte = b;
		r.last = 1'b0;
		return r;
	endfunction

	function automatic bit is_blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
	endfunction

	function automatic void tokenize_byte(input sat_in_t it, input bit record);
		sat_out_t res [2];
		int n;
		sat_state_t st;
		logic [7:0] c;
		bit keep;
		n = 0;
		c = it.in_byte;
		keep = 1'b0;
		st = parse_st;
		if (it.line_end) begin
			if (tok_open && !dropping) begin
				res[n] = make_result(KIND_TEND, 8'h00);
				n++;
			end
			res[n] = make_result(KIND_LEND, 8'h00);
			n++;
			parse_st = ST_SKIP;
			tok_open = 1'b0;
			tok_count = '0;
			dropping = 1'b0;
		end else if (!dropping) begin
			if (st == ST_SKIP && !is_blank(c))
				st = ST_TOK;
			case (st)
				ST_SKIP: ;
				ST_TOK: begin
					if (c == CH_SQUOTE)
						st = ST_Q1;
					else if (c == CH_DQUOTE)
						st = ST_Q2;
					else if (c == CH_BSLASH)
						st = ST_TOK_ESC;
					else if (is_blank(c)) begin
						st = ST_SKIP;
						if (tok_open) begin
							res[n] = make_result(KIND_TEND, 8'h00);
							n++;
							tok_open = 1'b0;
							if (tok_count >= tok_limit) begin
								res[n] = make_result(KIND_OVF, 8'h00);
								n++;
								dropping = 1'b1;
							end else begin
								tok_count = tok_count + 1'b1;
							end
						end
					end else
						keep = 1'b1;
				end
				ST_Q1: begin
					if (c == CH_SQUOTE)
						st = ST_TOK;
					else if (c == CH_BSLASH)
						st = ST_Q1_ESC;
					else
						keep = 1'b1;
				end
				ST_Q2: begin
					if (c == CH_DQUOTE)
						st = ST_TOK;
					else if (c == CH_BSLASH)
						st = ST_Q2_ESC;
					else
						keep = 1'b1;
				end
				ST_TOK_ESC: begin
					st = ST_TOK;
					keep = 1'b1;
				end
				ST_Q1_ESC: begin
					st = ST_Q1;
					keep = 1'b1;
				end
				default: begin
					st = ST_Q2;
					keep = 1'b1;
				end
			endcase
			if (keep) begin
				res[n] = make_result(KIND_BYTE, c);
				n++;
				tok_open = 1'b1;
			end
			parse_st = st;
		end
		if (n > 0)
			res[n-1].last = 1'b1;
		if (record)
			for (int i = 0; i < n; i++)
				due_token_stream.push_back(res[i]);
	endfunction

	function automatic dir_row_t row_in(input logic [7:0] b, input logic le);
		dir_row_t r;
		r = '0;
		r.item.in_byte = b;
		r.item.line_end = le;
		return r;
	endfunction

	function automatic dir_row_t row_one(input logic [7:0] b, input logic le,
			input logic [1:0] k0, input logic [7:0] b0);
		dir_row_t r;
		r = row_in(b, le);
		r.typed = 2'd1;
		r.r0 = make_result(k0, b0);
		r.r0.last = 1'b1;
		return r;
	endfunction

	function automatic dir_row_t row_two(input logic [7:0] b, input logic le,
			input logic [1:0] k0, input logic [7:0] b0,
			input logic [1:0] k1, input logic [7:0] b1);
		dir_row_t r;
		r = row_in(b, le);
		r.typed = 2'd2;
		r.r0 = make_result(k0, b0);
		r.r1 = make_result(k1, b1);
		r.r1.last = 1'b1;
		return r;
	endfunction

	function automatic dir_row_t row_cfg(input logic [LIMIT_W-1:0] v);
		dir_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.limit = v;
		return r;
	endfunction

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(3))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_CR;
			default: return CH_LF;
		endcase
	endfunction

	function automatic logic [7:0] pick_special();
		case ($urandom_range(6))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_CR;
			3: return CH_LF;
			4: return CH_SQUOTE;
			5: return CH_DQUOTE;
			default: return CH_BSLASH;
		endcase
	endfunction

	function automatic logic [7:0] pick_inner(input logic [7:0] quote);
		logic [7:0] b;
		do b = 8'($urandom_range(255)); while (b == quote || b == CH_BSLASH);
		return b;
	endfunction

	function automatic logic [7:0] pick_plain();
		logic [7:0] b;
		do b = 8'($urandom_range(255));
		while (is_blank(b) || b == CH_SQUOTE || b == CH_DQUOTE || b == CH_BSLASH);
		return b;
	endfunction

	task automatic send_item(input sat_in_t it);
		if ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic feed_byte(input logic [7:0] b);
		sat_in_t it;
		it.in_byte = b;
		it.line_end = 1'b0;
		send_item(it);
		tokenize_byte(it, 1'b1);
	endtask

	task automatic feed_line_end();
		sat_in_t it;
		it.in_byte = 8'($urandom_range(255));
		it.line_end = 1'b1;
		send_item(it);
		tokenize_byte(it, 1'b1);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] v);
		in_valid <= 1'b0;
		while (due_token_stream.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tok_limit = v;
		limit_writes++;
	endtask

	task automatic feed_quoted(input logic [7:0] q);
		int n;
		n = $urandom_range(3);
		feed_byte(q);
		repeat (n) begin
			if ($urandom_range(4) == 0) begin
				feed_byte(CH_BSLASH);
				feed_byte(8'($urandom_range(255)));
			end else begin
				feed_byte(pick_inner(q));
			end
		end
		feed_byte(q);
	endtask

	task automatic feed_token();
		int parts;
		parts = $urandom_range(1, 3);
		repeat (parts) begin
			case ($urandom_range(4))
				0, 1: repeat ($urandom_range(1, 4)) feed_byte(pick_plain());
				2: feed_quoted(CH_SQUOTE);
				3: feed_quoted(CH_DQUOTE);
				default: begin
					feed_byte(CH_BSLASH);
					feed_byte(8'($urandom_range(255)));
				end
			endcase
		end
	endtask

	task automatic feed_line();
		int top;
		int ntok;
		top = (tok_limit < 8) ? int'(tok_limit) + 2 : 10;
		ntok = $urandom_range(top);
		for (int t = 0; t < ntok; t++) begin
			if (t > 0 || $urandom_range(1))
				repeat ($urandom_range(1, 3)) feed_byte(pick_blank());
			feed_token();
		end
		if ($urandom_range(1))
			feed_byte(pick_blank());
		case ($urandom_range(9))
			0: feed_byte(CH_SQUOTE);
			1: feed_byte(CH_DQUOTE);
			2: feed_byte(CH_BSLASH);
			default: ;
		endcase
		feed_line_end();
	endtask

	task automatic feed_noise();
		int n;
		n = $urandom_range(16);
		repeat (n) begin
			if ($urandom_range(1))
				feed_byte(pick_special());
			else
				feed_byte(8'($urandom_range(255)));
		end
		if ($urandom_range(9) != 0)
			feed_line_end();
	endtask

	initial begin : stimulus
		int start;
		int waited;
		logic [LIMIT_W-1:0] lim;

		dir_rows.push_back(row_one(8'hFF, 1'b1, KIND_LEND, 8'h00));
		dir_rows.push_back(row_one(8'h00, 1'b0, KIND_BYTE, 8'h00));
		dir_rows.push_back(row_one(8'hFF, 1'b0, KIND_BYTE, 8'hFF));
		dir_rows.push_back(row_in(CH_SQUOTE, 1'b0));
		dir_rows.push_back(row_in(CH_BSLASH, 1'b0));
		dir_rows.push_back(row_in(CH_SQUOTE, 1'b0));
		dir_rows.push_back(row_in(CH_SQUOTE, 1'b0));
		dir_rows.push_back(row_in(CH_DQUOTE, 1'b0));
		dir_rows.push_back(row_in(CH_BSLASH, 1'b0));
		dir_rows.push_back(row_in(CH_DQUOTE, 1'b0));
		dir_rows.push_back(row_in(CH_LF, 1'b0));
		dir_rows.push_back(row_in(CH_DQUOTE, 1'b0));
		dir_rows.push_back(row_in(CH_BSLASH, 1'b0));
		dir_rows.push_back(row_in(CH_SPACE, 1'b0));
		dir_rows.push_back(row_one(CH_TAB, 1'b0, KIND_TEND, 8'h00));
		dir_rows.push_back(row_in(CH_SQUOTE, 1'b0));
		dir_rows.push_back(row_in(CH_SQUOTE, 1'b0));
		dir_rows.push_back(row_in(CH_CR, 1'b0));
		dir_rows.push_back(row_one(8'h00, 1'b1, KIND_LEND, 8'h00));
		dir_rows.push_back(row_cfg(10'd1));
		dir_rows.push_back(row_one(8'h61, 1'b0, KIND_BYTE, 8'h61));
		dir_rows.push_back(row_one(CH_SPACE, 1'b0, KIND_TEND, 8'h00));
		dir_rows.push_back(row_one(8'h62, 1'b0, KIND_BYTE, 8'h62));
		dir_rows.push_back(row_two(CH_SPACE, 1'b0, KIND_TEND, 8'h00, KIND_OVF, 8'h00));
		dir_rows.push_back(row_in(8'h63, 1'b0));
		dir_rows.push_back(row_one(8'h00, 1'b1, KIND_LEND, 8'h00));
		dir_rows.push_back(row_one(8'h71, 1'b0, KIND_BYTE, 8'h71));
		dir_rows.push_back(row_in(CH_DQUOTE, 1'b0));
		dir_rows.push_back(row_two(8'h00, 1'b1, KIND_TEND, 8'h00, KIND_LEND, 8'h00));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				write_limit(dir_rows[i].limit);
			end else begin
				send_item(dir_rows[i].item);
				if (dir_rows[i].typed == 2'd0) begin
					tokenize_byte(dir_rows[i].item, 1'b1);
				end else begin
					tokenize_byte(dir_rows[i].item, 1'b0);
					due_token_stream.push_back(dir_rows[i].r0);
					if (dir_rows[i].typed == 2'd2)
						due_token_stream.push_back(dir_rows[i].r1);
				end
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: lim = 10'd1023;
				1: lim = 10'd2;
				2: lim = 10'd1;
				3: lim = LIMIT_W'($urandom_range(1, 1023));
				4: lim = 10'd3;
				5: lim = LIMIT_W'($urandom_range(1, 6));
				6: lim = 10'd4;
				default: lim = LIMIT_W'($urandom_range(1, 8));
			endcase
			if (p < 3) begin
				in_idle_pct = 31;
				out_idle_pct = 47;
			end else if (p < 6) begin
				in_idle_pct = 47;
				out_idle_pct = 31;
			end else begin
				in_idle_pct = 0;
				out_idle_pct = 0;
			end
			write_limit(lim);
			start = items_sent;
			while (items_sent - start < ITEMS_PER_PHASE) begin
				if ($urandom_range(99) < 85)
					feed_line();
				else
					feed_noise();
			end
		end

		in_valid <= 1'b0;
		waited = 0;
		while (due_token_stream.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (due_token_stream.size() != 0)
			report_mismatch("results never delivered, count", 0, due_token_stream.size());

		$display("Run covered %0d input transfers over %0d token limit settings.",
			items_sent, limit_writes);
		$display("Checked %0d output transfers, %0d of them overflow markers; %0d mismatches.",
			results_checked, overflow_marks, mismatches);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/sat_pkg.sv
hw/rtl/sat_step.sv
hw/rtl/sat_fifo.sv
hw/rtl/shell_argument_tokenizer.sv
hw/rtl/sat_checker.sv
tb/shell_argument_tokenizer_tb.sv
